[rtl/psfd_pkg.sv]
// Shared types, constants and the CRC-8 helper for the pressure sensor frame decoder.
package psfd_pkg;

    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [3:0] LAST_BYTE = 4'd8;
    localparam logic [6:0] CENTI     = 7'd100;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;

    localparam int QUO_W = 22;   // |pressure*100| < 2^22
    localparam int DIV_W = 16;   // |scale| <= 2^15
    localparam int CNT_W = 5;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_CHECK
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pressure_raw;
        logic [15:0] temperature_raw;
        logic [15:0] scale_raw;
    } t_job;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[rtl/psfd_front.sv]
// Byte intake: index tracking, CRC check and word assembly; emits one job per reply.
module psfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    output logic                o_stall,
    input  logic                i_q_full,
    output logic                o_push,
    output psfd_pkg::t_job      o_job
);
    import psfd_pkg::*;

    logic [3:0] r_idx;
    logic [7:0] r_crc;
    logic       r_good;
    logic [7:0] r_hold;
    logic [15:0] r_pressure_raw;
    logic [15:0] r_temperature_raw;
    logic [15:0] r_scale_raw;

    logic [3:0]  pos;
    logic [7:0]  crc_eff;
    logic        good_eff;
    logic [7:0]  crc_next;
    logic [15:0] word;
    logic        accept;
    logic        crc_match;
    t_phase      phase;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        pos      = i_frame_start ? 4'd0 : r_idx;
        if (pos > LAST_BYTE) begin
            pos = 4'd0;
        end
        crc_eff  = i_frame_start ? CRC_INIT : r_crc;
        good_eff = i_frame_start ? 1'b1 : r_good;
        crc_next = crc_update(crc_eff, i_rx_byte);
        word     = {r_hold, i_rx_byte};
        crc_match = (crc_eff == i_rx_byte);
        unique case (pos)
            4'd0, 4'd3, 4'd6: phase = PH_HIGH;
            4'd1, 4'd4, 4'd7: phase = PH_LOW;
            default:          phase = PH_CHECK;
        endcase
    end

    assign o_push = accept && (pos == LAST_BYTE);

    always_comb begin
        o_job.pressure_raw    = r_pressure_raw;
        o_job.temperature_raw = r_temperature_raw;
        o_job.scale_raw       = r_scale_raw;
        priority if (!(good_eff && crc_match)) begin
            o_job.status = ST_CRC;
        end else if (r_scale_raw == 16'd0) begin
            o_job.status = ST_SCALE;
        end else begin
            o_job.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 4'd0;
            r_crc  <= CRC_INIT;
            r_good <= 1'b1;
        end else if (accept) begin
            r_idx <= (pos == LAST_BYTE) ? 4'd0 : pos + 4'd1;
            unique case (phase)
                PH_HIGH, PH_LOW: begin
                    r_crc  <= crc_next;
                    r_good <= good_eff;
                end
                default: begin
                    r_crc  <= CRC_INIT;
                    r_good <= (pos == LAST_BYTE) ? 1'b1 : (good_eff && crc_match);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (phase == PH_HIGH) begin
                r_hold <= i_rx_byte;
            end
            if (phase == PH_LOW) begin
                unique case (pos)
                    4'd1:    r_pressure_raw    <= word;
                    4'd4:    r_temperature_raw <= word;
                    default: r_scale_raw       <= word;
                endcase
            end
        end
    end

endmodule

[rtl/psfd_queue.sv]
// Two-entry job queue between intake and conversion.
module psfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psfd_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output psfd_pkg::t_job  o_job
);
    import psfd_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/psfd_back.sv]
// Conversion: temperature halving and a radix-2 signed divider for pressure.
module psfd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  psfd_pkg::t_job         i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic signed [22:0]     o_pressure_centipa,
    output logic signed [14:0]     o_temperature_centic
);
    import psfd_pkg::*;

    t_back_state r_state, n_state;

    logic [CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic             r_neg;
    logic [1:0]       r_status;
    logic signed [22:0] r_p;
    logic signed [14:0] r_t;

    logic              load;
    logic              div_last;
    logic signed [22:0] p_scaled;
    logic [QUO_W-1:0]  p_mag;
    logic [DIV_W-1:0]  s_mag;
    logic [16:0]       t_adj;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic [QUO_W-1:0]  quo_next;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_job.status == ST_OK) ? BK_DIV : BK_OUT;
                end
            end
            BK_DIV: begin
                if (div_last) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!i_stall) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        load    = (r_state == BK_IDLE) && !i_q_empty;
        o_pop   = load;
        o_valid = (r_state == BK_OUT);
    end

    assign div_last = (r_cnt == CNT_W'(QUO_W - 1));

    always_comb begin
        p_scaled = 23'($signed(i_job.pressure_raw)) * $signed({1'b0, CENTI});
        p_mag    = p_scaled[22] ? QUO_W'(-p_scaled) : QUO_W'(p_scaled);
        s_mag    = i_job.scale_raw[15] ? DIV_W'(-i_job.scale_raw) : i_job.scale_raw;
        // x*100/200 is x/2 toward zero
        t_adj    = {i_job.temperature_raw[15], i_job.temperature_raw}
                   + {16'd0, i_job.temperature_raw[15]};
        trial    = {r_rem, r_quo[QUO_W-1]};
        diff     = trial - {1'b0, r_div};
        quo_next = {r_quo[QUO_W-2:0], ~diff[DIV_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_job.status;
            r_t      <= (i_job.status == ST_CRC) ? 15'sd0 : $signed(t_adj[15:1]);
            r_p      <= 23'sd0;
            r_quo    <= p_mag;
            r_rem    <= '0;
            r_div    <= s_mag;
            r_neg    <= i_job.pressure_raw[15] ^ i_job.scale_raw[15];
            r_cnt    <= '0;
        end else if (r_state == BK_DIV) begin
            r_quo <= quo_next;
            r_rem <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
            if (div_last) begin
                r_p <= r_neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            end
        end
    end

    assign o_status             = r_status;
    assign o_pressure_centipa   = r_p;
    assign o_temperature_centic = r_t;

endmodule

[rtl/pressure_sensor_frame_decoder_top.sv]
// Top level of the pressure sensor frame decoder.
//   channel | direction | signals
//   input   | in        | i_valid, o_stall, i_rx_byte, i_frame_start
//   output  | out       | o_valid, i_stall, o_status, o_pressure_centipa,
//           |           | o_temperature_centic
// The ninth byte of a reply queues one job (two deep).
// Conversion loads the job, runs the shift-subtract divider when the status is ok
// (skipped otherwise), then the result register waits for the sink.
// Synchronous active-low reset clears index, CRC, queue and result valid.
// Input stalls only while the job queue is full.
module pressure_sensor_frame_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [22:0] o_pressure_centipa,
    output logic signed [14:0] o_temperature_centic
);
    import psfd_pkg::*;

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    psfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_stall       (o_stall),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    psfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    psfd_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_empty            (q_empty),
        .i_job                (pop_job),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_pressure_centipa   (o_pressure_centipa),
        .o_temperature_centic (o_temperature_centic)
    );

endmodule
